FILE: rtl/core/spq_pkg.sv
package spq_pkg;

  typedef enum logic [1:0] {
    ST_INSERTED     = 2'd0,
    ST_REMOVED      = 2'd1,
    ST_EMPTY_REMOVE = 2'd2,
    ST_FULL_DROP    = 2'd3
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

endpackage

FILE: rtl/core/spq_cell.sv
module spq_cell #(
  parameter int ITEM_WIDTH     = 16,
  parameter int PRIORITY_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::spq_ctrl_t        ctrl_i,
  input  logic [ITEM_WIDTH-1:0]     new_item_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  input  logic                      prev_ge_i,
  input  logic                      prev_valid_i,
  input  logic [ITEM_WIDTH-1:0]     prev_item_i,
  input  logic [PRIORITY_WIDTH-1:0] prev_prio_i,
  input  logic                      next_valid_i,
  input  logic [ITEM_WIDTH-1:0]     next_item_i,
  input  logic [PRIORITY_WIDTH-1:0] next_prio_i,
  output logic                      ge_o,
  output logic                      valid_o,
  output logic [ITEM_WIDTH-1:0]     item_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o
);
  import spq_pkg::*;

  logic                      valid_q, valid_d;
  logic [ITEM_WIDTH-1:0]     item_q, item_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;

  assign ge_o = !valid_q || (prio_q >= new_prio_i);

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    prio_d  = prio_q;
    priority if (ctrl_i.rem) begin
      valid_d = next_valid_i;
      item_d  = next_item_i;
      prio_d  = next_prio_i;
    end else if (ctrl_i.ins && ge_o && !prev_ge_i) begin
      valid_d = 1'b1;
      item_d  = new_item_i;
      prio_d  = new_prio_i;
    end else if (ctrl_i.ins && ge_o) begin
      valid_d = prev_valid_i;
      item_d  = prev_item_i;
      prio_d  = prev_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign prio_o  = prio_q;

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   req_type_i, item_in_i, priority_in_i
// out      source     out_valid_o / out_stall_i status_o, item_out_o, priority_out_o,
//                                               now_empty_o
//
// One transfer per cycle unless the output stalls: every cell compares its priority
// with the new one at once and all cells shift together in the same clock.
// The result is registered in the output register in the cycle after the input transfer.
// Reset clears the cell valid bits and the output register; payload is not reset.
// A stalled result stalls the input until the output register frees up.
module sorted_priority_queue #(
  parameter int DEPTH          = 64,
  parameter int ITEM_WIDTH     = 16,
  parameter int PRIORITY_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [ITEM_WIDTH-1:0]     item_in_i,
  input  logic [PRIORITY_WIDTH-1:0] priority_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [ITEM_WIDTH-1:0]     item_out_o,
  output logic [PRIORITY_WIDTH-1:0] priority_out_o,
  output logic                      now_empty_o
);
  import spq_pkg::*;

  logic [DEPTH-1:0]          valid_w;
  logic [DEPTH-1:0]          ge_w;
  logic [ITEM_WIDTH-1:0]     item_w [DEPTH];
  logic [PRIORITY_WIDTH-1:0] prio_w [DEPTH];

  logic      in_xfer;
  logic      is_remove;
  logic      full;
  logic      empty;
  spq_ctrl_t ctrl;

  logic                      out_valid_q;
  status_e                   status_q, status_d;
  logic [ITEM_WIDTH-1:0]     item_q, item_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic                      empty_q, empty_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign is_remove  = (req_e'(req_type_i) == REQ_REMOVE);
  assign full       = valid_w[DEPTH-1];
  assign empty      = !valid_w[0];

  assign ctrl.ins = in_xfer && !is_remove && !full;
  assign ctrl.rem = in_xfer && is_remove && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      prev_ge, prev_valid, next_valid;
    logic [ITEM_WIDTH-1:0]     prev_item, next_item;
    logic [PRIORITY_WIDTH-1:0] prev_prio, next_prio;

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_item  = '0;
      assign prev_prio  = '0;
    end else begin : g_body
      assign prev_ge    = ge_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_item  = item_w[i-1];
      assign prev_prio  = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_item  = '0;
      assign next_prio  = '0;
    end else begin : g_link
      assign next_valid = valid_w[i+1];
      assign next_item  = item_w[i+1];
      assign next_prio  = prio_w[i+1];
    end

    spq_cell #(
      .ITEM_WIDTH    (ITEM_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_item_i  (item_in_i),
      .new_prio_i  (priority_in_i),
      .prev_ge_i   (prev_ge),
      .prev_valid_i(prev_valid),
      .prev_item_i (prev_item),
      .prev_prio_i (prev_prio),
      .next_valid_i(next_valid),
      .next_item_i (next_item),
      .next_prio_i (next_prio),
      .ge_o        (ge_w[i]),
      .valid_o     (valid_w[i]),
      .item_o      (item_w[i]),
      .prio_o      (prio_w[i])
    );
  end

  always_comb begin
    item_d = '0;
    prio_d = '0;
    if (is_remove) begin
      if (empty) begin
        status_d = ST_EMPTY_REMOVE;
        empty_d  = 1'b1;
      end else begin
        status_d = ST_REMOVED;
        item_d   = item_w[0];
        prio_d   = prio_w[0];
        empty_d  = !valid_w[1];
      end
    end else begin
      status_d = full ? ST_FULL_DROP : ST_INSERTED;
      empty_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_INSERTED;
      empty_q     <= 1'b1;
    end else begin
      if (in_xfer) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        empty_q     <= empty_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
      prio_q <= prio_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign item_out_o     = item_q;
  assign priority_out_o = prio_q;
  assign now_empty_o    = empty_q;

  logic [DEPTH:0] valid_inc;
  assign valid_inc = {1'b0, valid_w} + {{DEPTH{1'b0}}, 1'b1};

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(valid_inc))
    else $error("cell valid bits not packed toward the head");

  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && is_remove && empty |=> status_o == ST_EMPTY_REMOVE && now_empty_o)
    else $error("remove on empty queue not reported");

  a_insert_fills_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> valid_w[0])
    else $error("head cell empty after insert");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_xfer) && out_valid_o |-> now_empty_o == !valid_w[0])
    else $error("empty flag disagrees with cell chain");

endmodule
